>>> rtl/core/cspsum_pkg.sv
package cspsum_pkg;

	localparam int SEEN_DEPTH = 64;
	localparam int DATA_W     = 32;

	typedef logic [DATA_W-1:0] word_t;

	// per-cycle commands broadcast to every cell of the chain
	typedef struct packed {
		logic shift;
		logic clear;
	} chain_ctrl_t;

	// reduced lookup status from the chain
	typedef struct packed {
		logic comp_hit;
		logic self_hit;
		logic full;
	} chain_stat_t;

endpackage

>>> rtl/core/cspsum_cell.sv
module cspsum_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cspsum_pkg::chain_ctrl_t  ctrl,
	input  cspsum_pkg::word_t        prev_val,
	input  logic                     prev_vld,
	input  cspsum_pkg::word_t        comp_key,
	input  logic                     comp_ok,
	input  cspsum_pkg::word_t        self_key,
	output cspsum_pkg::word_t        val_q,
	output logic                     vld_q,
	output logic                     comp_hit,
	output logic                     self_hit
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.clear) begin
			vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			vld_q <= prev_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q <= prev_val;
		end
	end

	assign comp_hit = vld_q && comp_ok && (val_q == comp_key);
	assign self_hit = vld_q && (val_q == self_key);

endmodule

>>> rtl/core/cspsum_chain.sv
module cspsum_chain (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cspsum_pkg::chain_ctrl_t  ctrl,
	input  cspsum_pkg::word_t        new_val,
	input  cspsum_pkg::word_t        comp_key,
	input  logic                     comp_ok,
	output cspsum_pkg::chain_stat_t  stat
);

	cspsum_pkg::word_t                    val   [cspsum_pkg::SEEN_DEPTH];
	logic [cspsum_pkg::SEEN_DEPTH-1:0]    vld;
	logic [cspsum_pkg::SEEN_DEPTH-1:0]    c_hit;
	logic [cspsum_pkg::SEEN_DEPTH-1:0]    s_hit;

	// new entries enter at cell 0 and push older ones toward the tail
	for (genvar i = 0; i < cspsum_pkg::SEEN_DEPTH; i++) begin : g_cell
		cspsum_pkg::word_t prev_val;
		logic              prev_vld;
		if (i == 0) begin : g_head
			assign prev_val = new_val;
			assign prev_vld = 1'b1;
		end else begin : g_link
			assign prev_val = val[i-1];
			assign prev_vld = vld[i-1];
		end
		cspsum_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.prev_val (prev_val),
			.prev_vld (prev_vld),
			.comp_key (comp_key),
			.comp_ok  (comp_ok),
			.self_key (new_val),
			.val_q    (val[i]),
			.vld_q    (vld[i]),
			.comp_hit (c_hit[i]),
			.self_hit (s_hit[i])
		);
	end

	assign stat.comp_hit = |c_hit;
	assign stat.self_hit = |s_hit;
	assign stat.full     = vld[cspsum_pkg::SEEN_DEPTH-1];

	// occupied cells always form a contiguous run from the head
	a_vld_contig: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("chain valid bits not contiguous");

endmodule

>>> rtl/core/complement_set_pair_sum_core.sv
// Two-sum search over a stream of sets.
//
// Item channel (item_valid / item_stall): value plus last_item. A transfer
// happens at a clock edge with valid high and stall low. The value's
// complement (target_sum - value) is formed on entry, then checked against
// every stored value by a chain of 64 cells.
// Result channel (result_valid / result_stall): at most one result per set,
// either the first pair found or a not-found result at the last item, with
// overflow set when the store ran full and values were dropped.
// An item is registered in the lookup stage, its result then in the output
// register once that is free. Throughput: one item per cycle while item_stall
// is low; the lookup plus store update is the loop that sets it. item_stall
// rises only when a result is ready while the output register still holds
// an untaken one. The user writes target_sum through target_sum_we only while
// the block is idle; the block does not enforce this. Reset (arst_n low)
// empties the store, clears the per-set and valid flags and the target. The
// store and flags are cleared after the last item of every set.
module complement_set_pair_sum_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 target_sum_we,
	input  logic signed [cspsum_pkg::DATA_W-1:0] target_sum,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic signed [cspsum_pkg::DATA_W-1:0] value,
	input  logic                                 last_item,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 found,
	output logic signed [cspsum_pkg::DATA_W-1:0] current_value,
	output logic signed [cspsum_pkg::DATA_W-1:0] partner_value,
	output logic                                 overflow
);

	localparam int W = cspsum_pkg::DATA_W;

	// config
	cspsum_pkg::word_t target_q;

	// entry: complement in W+1 bits, in range when the top two bits agree
	logic [W:0]        diff;
	logic              item_xfer;

	// lookup stage
	logic              s1_valid_q;
	cspsum_pkg::word_t value_s1;
	logic              last_s1;
	cspsum_pkg::word_t comp_s1;
	logic              comp_ok_s1;

	// per-set flags
	logic              pair_done_q;
	logic              ovf_q;

	// output register
	logic              res_valid_q;
	logic              found_q;
	cspsum_pkg::word_t cur_q;
	cspsum_pkg::word_t partner_q;
	logic              ovf_out_q;

	cspsum_pkg::chain_ctrl_t ctrl;
	cspsum_pkg::chain_stat_t stat;

	logic active, hit, miss, keep, emit, out_free, s1_go, ovf_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_sum_we) begin
			target_q <= target_sum;
		end
	end

	assign diff      = {target_q[W-1], target_q} - {value[W-1], value};
	assign item_xfer = item_valid && !item_stall;

	// lookup decisions for the item in the stage
	always_comb begin
		active   = s1_valid_q && !pair_done_q;
		hit      = active && stat.comp_hit;
		miss     = active && !stat.comp_hit;
		keep     = miss && !stat.self_hit;   // new distinct value
		emit     = hit || (miss && last_s1);
		ovf_now  = ovf_q || (keep && stat.full);
		out_free = !res_valid_q || !result_stall;
		s1_go    = s1_valid_q && (!emit || out_free);
		ctrl.shift = s1_go && keep && !stat.full;
		ctrl.clear = s1_go && last_s1;
	end

	assign item_stall = s1_valid_q && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (item_xfer) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			value_s1   <= value;
			last_s1    <= last_item;
			comp_s1    <= diff[W-1:0];
			comp_ok_s1 <= (diff[W] == diff[W-1]);
		end
	end

	// set flags clear on the last item whatever happened in the set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_done_q <= 1'b0;
			ovf_q       <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				pair_done_q <= 1'b0;
				ovf_q       <= 1'b0;
			end else begin
				pair_done_q <= pair_done_q || hit;
				ovf_q       <= ovf_now;
			end
		end
	end

	cspsum_chain u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.new_val  (value_s1),
		.comp_key (comp_s1),
		.comp_ok  (comp_ok_s1),
		.stat     (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// on a match the partner equals the complement, so no read of the store
	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			found_q   <= hit;
			cur_q     <= hit ? value_s1 : '0;
			partner_q <= hit ? comp_s1 : '0;
			ovf_out_q <= ovf_now;
		end
	end

	assign result_valid  = res_valid_q;
	assign found         = found_q;
	assign current_value = cur_q;
	assign partner_value = partner_q;
	assign overflow      = ovf_out_q;

	a_nf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !found_q) |-> (cur_q == '0 && partner_q == '0))
		else $error("not-found result carries nonzero values");

	a_pair_sum: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && found_q) |-> (W'(cur_q + partner_q) == target_q))
		else $error("reported pair does not reach target");

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (s1_valid_q && emit && res_valid_q))
		else $error("item stalled without a blocked result");

endmodule

>>> bench/complement_set_pair_sum_check.sv
module complement_set_pair_sum_check
	import cspsum_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  target_sum_we,
	input  word_t target_sum,
	input  logic  item_valid,
	input  logic  item_stall,
	input  word_t value,
	input  logic  last_item,
	input  logic  result_valid,
	input  logic  result_stall,
	input  logic  found,
	input  word_t current_value,
	input  word_t partner_value,
	input  logic  overflow,
	output int    errors,
	output int    pending,
	output int    live_items
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic  found;
		word_t current;
		word_t partner;
		logic  dropped;
	} pair_result_t;

	pair_result_t awaited_results[$];
	word_t        seen_values[$];
	word_t        target_copy = '0;
	logic         pair_reported = 1'b0;
	logic         values_dropped = 1'b0;
	int           fail_total = 0;
	int           live_total = 0;

	function automatic bit seen_holds(input longint x);
		foreach (seen_values[i])
			if (longint'($signed(seen_values[i])) == x)
				return 1'b1;
		return 1'b0;
	endfunction

	// complement is taken in 64-bit math, so an out-of-range one never matches
	function automatic void predict_pair(input word_t v, input logic last);
		longint       comp;
		pair_result_t res;
		comp = longint'($signed(target_copy)) - longint'($signed(v));
		if (!pair_reported) begin
			live_total++;
			if (seen_holds(comp)) begin
				res = '{1'b1, v, comp[DATA_W-1:0], values_dropped};
				awaited_results.push_back(res);
				pair_reported = 1'b1;
			end else begin
				if (!seen_holds(longint'($signed(v)))) begin
					if (seen_values.size() < SEEN_DEPTH)
						seen_values.push_back(v);
					else
						values_dropped = 1'b1;
				end
				if (last) begin
					res = '{1'b0, '0, '0, values_dropped};
					awaited_results.push_back(res);
				end
			end
		end
		if (last) begin
			seen_values.delete();
			pair_reported = 1'b0;
			values_dropped = 1'b0;
		end
	endfunction

	function automatic bit field_ok(input string name, input word_t want, input word_t got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
			return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pair_result_t want;
		bit           ok;
		if (!arst_n) begin
			target_copy = '0;
			seen_values.delete();
			awaited_results.delete();
			pair_reported = 1'b0;
			values_dropped = 1'b0;
		end else begin
			// result side first: an item taken on this edge cannot have its result yet
			if (result_valid && !result_stall) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result, found=%0b current=%0d partner=%0d",
						$time, found, $signed(current_value), $signed(partner_value));
					$display("%0t: unexpected result, overflow=%0b", $time, overflow);
					fail_total++;
				end else begin
					want = awaited_results.pop_front();
					ok = field_ok("found", word_t'(want.found), word_t'(found));
					ok = field_ok("current_value", want.current, current_value) && ok;
					ok = field_ok("partner_value", want.partner, partner_value) && ok;
					ok = field_ok("overflow", word_t'(want.dropped), word_t'(overflow)) && ok;
					if (!ok)
						fail_total++;
				end
			end
			if (target_sum_we)
				target_copy = target_sum;
			if (item_valid && !item_stall)
				predict_pair(value, last_item);
		end
		errors     <= fail_total;
		pending    <= awaited_results.size();
		live_items <= live_total;
	end

endmodule

>>> bench/complement_set_pair_sum_core_tb.sv
module complement_set_pair_sum_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cspsum_pkg::*;

	// stop making sets once this many items were taken while a search was open
	localparam int     LIVE_GOAL   = 700;
	// worst case, every item with the longest gap and stall, is far below this
	localparam int     CYCLE_LIMIT = 400000;
	// result is registered after the lookup stage; leave some slack
	localparam int     SETTLE      = 6;
	localparam word_t  WORD_MIN    = 32'h8000_0000;
	localparam word_t  WORD_MAX    = 32'h7fff_ffff;
	localparam longint TARGET_MIN  = -64'sd2147483648;
	localparam longint TARGET_MAX  = 64'sd2147483647;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     target_sum_we = 1'b0;
	logic signed [DATA_W-1:0] target_sum = '0;
	logic                     item_valid = 1'b0;
	logic                     item_stall;
	logic signed [DATA_W-1:0] value = '0;
	logic                     last_item = 1'b0;
	logic                     result_valid;
	logic                     result_stall = 1'b1;
	logic                     found;
	logic signed [DATA_W-1:0] current_value;
	logic signed [DATA_W-1:0] partner_value;
	logic                     overflow;

	int     fail_count;
	int     pending_results;
	int     live_items;
	int     cycle_count = 0;
	// calm sets run with no gaps on either side
	bit     calm = 1'b0;
	// host copy of target_sum, used to aim values at real pairs
	longint cur_target = 0;
	word_t  set_values[$];

	always #4 clk = ~clk;

	complement_set_pair_sum_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.target_sum_we (target_sum_we),
		.target_sum    (target_sum),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.value         (value),
		.last_item     (last_item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.found         (found),
		.current_value (current_value),
		.partner_value (partner_value),
		.overflow      (overflow)
	);

	complement_set_pair_sum_check u_pair_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.target_sum_we (target_sum_we),
		.target_sum    (target_sum),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.value         (value),
		.last_item     (last_item),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.found         (found),
		.current_value (current_value),
		.partner_value (partner_value),
		.overflow      (overflow),
		.errors        (fail_count),
		.pending       (pending_results),
		.live_items    (live_items)
	);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Result side: random stall before each transfer.
	initial begin : result_drain
		int gap;
		forever begin
			gap = calm ? 0 : $urandom_range(0, 16);
			if (gap != 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	// One item transfer, after a random gap with valid low.
	task automatic send_item(input word_t v, input logic last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		value      <= v;
		last_item  <= last;
		do @(posedge clk); while (item_stall);
	endtask

	// Send set_values as one set; last_item rides on the final value.
	task automatic send_set();
		calm = ($urandom_range(0, 3) == 0);
		foreach (set_values[i])
			send_item(set_values[i], i == set_values.size() - 1);
	endtask

	// Block is idle once no result is outstanding. The count from the checker
	// is registered, so look in the cycle after the last transfer; silent
	// items after a match get the settle time.
	task automatic wait_idle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_target(input longint t);
		wait_idle();
		target_sum_we <= 1'b1;
		target_sum    <= t[DATA_W-1:0];
		cur_target     = t;
		@(posedge clk);
		target_sum_we <= 1'b0;
	endtask

	// Random set. Short sets aim at pairs: values near target/2, complements
	// and repeats of earlier values, mixed with noise and extremes. Long sets
	// are mostly unrelated values so the store fills and drops.
	task automatic random_set();
		int     len;
		int     pick;
		longint half;
		longint w;
		word_t  v;
		set_values.delete();
		len  = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 12);
		half = cur_target >>> 1;
		for (int i = 0; i < len; i++) begin
			pick = (len > 12) ? 6 : $urandom_range(0, 9);
			v = $urandom;
			case (pick)
				0, 1, 2, 3: begin
					w = half + longint'($urandom_range(0, 16)) - 8;
					v = w[DATA_W-1:0];
				end
				4, 5: begin
					if (set_values.size() != 0) begin
						w = cur_target -
							longint'($signed(set_values[$urandom_range(0, set_values.size() - 1)]));
						if (w >= TARGET_MIN && w <= TARGET_MAX)
							v = w[DATA_W-1:0];
					end
				end
				8: begin
					case ($urandom_range(0, 3))
						0: v = WORD_MIN;
						1: v = WORD_MAX;
						2: v = '0;
						default: v = '1;
					endcase
				end
				9: begin
					if (set_values.size() != 0)
						v = set_values[$urandom_range(0, set_values.size() - 1)];
				end
				default: ;
			endcase
			set_values.push_back(v);
		end
		// long set may close with the partner of its first value
		if (len > 12 && $urandom_range(0, 1) == 1) begin
			w = cur_target - longint'($signed(set_values[0]));
			if (w >= TARGET_MIN && w <= TARGET_MAX)
				set_values[len - 1] = w[DATA_W-1:0];
		end
		send_set();
	endtask

	initial begin
		longint phase_target;
		int     sets;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		write_target(0);
		set_values = '{5, -5};            // pair on the last item
		send_set();
		set_values = '{42};               // single item, not found
		send_set();
		set_values = '{1, -1, 7, 8};      // items after the match stay silent
		send_set();

		write_target(10);
		set_values = '{3, 3, 5, 5};       // duplicate is kept once; 5+5 pairs
		send_set();

		write_target(-1);
		set_values = '{WORD_MIN, WORD_MAX};
		send_set();
		set_values = '{0, -1};
		send_set();

		// complement out of 32-bit range must not wrap into a match
		write_target(TARGET_MIN);
		set_values = '{WORD_MAX, 1};
		send_set();
		write_target(TARGET_MAX);
		set_values = '{WORD_MIN, -1};
		send_set();
		set_values = '{0, WORD_MAX};
		send_set();

		// store full: 65 and 66 are dropped, so -65 finds nothing and
		// -2 pairs with 2 with overflow set
		write_target(0);
		set_values.delete();
		for (int i = 1; i <= 66; i++)
			set_values.push_back(i);
		set_values.push_back(-65);
		set_values.push_back(-2);
		send_set();
		// full store, no pair
		set_values.delete();
		for (int i = 100; i <= 170; i++)
			set_values.push_back(i);
		send_set();

		// --- random phases, each with its own target ---
		while (live_items < LIVE_GOAL) begin
			case ($urandom_range(0, 5))
				0: phase_target = TARGET_MIN;
				1: phase_target = TARGET_MAX;
				2: phase_target = 0;
				3: phase_target = -1;
				4: phase_target = longint'($urandom_range(0, 200)) - 100;
				default: phase_target = longint'($signed(32'($urandom)));
			endcase
			write_target(phase_target);
			sets = $urandom_range(4, 12);
			repeat (sets) random_set();
		end

		wait_idle();
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> complement_set_pair_sum_core.f
rtl/core/cspsum_pkg.sv
rtl/core/cspsum_cell.sv
rtl/core/cspsum_chain.sv
rtl/core/complement_set_pair_sum_core.sv
bench/complement_set_pair_sum_check.sv
bench/complement_set_pair_sum_core_tb.sv
